// ----- hw/rtl/qmm_pkg.sv -----
// ----------------------------------------------------------------------------
// qmm_pkg: shared types and constants
// field widths, item kinds, register indexes and payload structs for the
// quad motor mixer and esc pulse generator
// ----------------------------------------------------------------------------
package qmm_pkg;

	localparam int KIND_W     = 3;
	localparam int THR_W      = 12;
	localparam int COR_W      = 11;
	localparam int WID_W      = 13;
	localparam int PHASE_W    = 16;
	localparam int ARM_W      = 24;
	localparam int LIM_W      = 11;
	localparam int NUM_MOTORS = 4;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 24;

	// item kinds
	localparam logic [KIND_W-1:0] KIND_TICK   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_MIX    = 3'd1;
	localparam logic [KIND_W-1:0] KIND_ARM    = 3'd2;
	localparam logic [KIND_W-1:0] KIND_STOP   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_SILENT = 3'd4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ESC_LOW_LIMIT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ARM_DURATION  = 1'b1;

	// reset values and fixed offsets
	localparam logic [LIM_W-1:0]   ESC_LOW_RESET    = 11'd1000;
	localparam logic [ARM_W-1:0]   ARM_DUR_RESET    = 24'd3000000;
	localparam logic [LIM_W-1:0]   LOW_PULSE_OFFSET = 11'd100;
	localparam logic [LIM_W-1:0]   SILENT_OFFSET    = 11'd50;
	localparam logic [PHASE_W-1:0] ARM_LOW_TICKS    = 16'd1000;
	localparam logic [ARM_W-1:0]   ARM_MAX          = '1;

	typedef logic [WID_W-1:0] width_t;
	typedef logic [NUM_MOTORS-1:0][WID_W-1:0] width_vec_t;
	typedef logic [NUM_MOTORS-1:0] pins_t;

	typedef struct packed {
		logic [KIND_W-1:0]       kind;
		logic [THR_W-1:0]        throttle;
		logic signed [COR_W-1:0] pitch;
		logic signed [COR_W-1:0] roll;
		logic signed [COR_W-1:0] yaw;
	} item_t;

	typedef struct packed {
		pins_t motor_pins;
		logic  busy_res;
		logic  armed;
		logic  rejected;
	} res_t;

endpackage

// ----- hw/rtl/qmm_if.sv -----
// ----------------------------------------------------------------------------
// qmm channel interfaces
// valid/ready channels for command items and result items
// ----------------------------------------------------------------------------
interface qmm_item_if;
	import qmm_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [KIND_W-1:0]       kind;
	logic [THR_W-1:0]        throttle;
	logic signed [COR_W-1:0] pitch;
	logic signed [COR_W-1:0] roll;
	logic signed [COR_W-1:0] yaw;

	modport source (output valid, kind, throttle, pitch, roll, yaw, input ready);
	modport sink (input valid, kind, throttle, pitch, roll, yaw, output ready);
endinterface

interface qmm_res_if;
	import qmm_pkg::*;

	logic              valid;
	logic              ready;
	logic [NUM_MOTORS-1:0] motor_pins;
	logic              busy_res;
	logic              armed;
	logic              rejected;

	modport source (output valid, motor_pins, busy_res, armed, rejected, input ready);
	modport sink (input valid, motor_pins, busy_res, armed, rejected, output ready);
endinterface

// ----- hw/rtl/quad_motor_mix_esc_pulse_generator_unit.sv -----
// ----------------------------------------------------------------------------
// quad_motor_mix_esc_pulse_generator_unit: x mixer and esc pulse generator
// tick and command items in, one pin/status result out per item
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake        payload
//   item      in         valid / ready    kind, throttle, pitch, roll, yaw
//   result    out        valid / ready    motor_pins, busy_res, armed, rejected
//   wr_*      in         wr_en only       wr_index, wr_data
//
// one item per cycle sustained while the result is not stalled; an item reaches the result
// through the input register, then the sequencer with its result register
// arst_n clears the mode, counters, pins, armed flag and both channel stages;
// the registers return to esc_low_limit 1000 and arm_duration 3000000
// a stalled result register holds the input stage, which then drops ready
// configuration, which the block does not guard, is for the user to write only while no item is in flight
// ----------------------------------------------------------------------------
module quad_motor_mix_esc_pulse_generator_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [qmm_pkg::CFG_IDX_W-1:0]   wr_index,
	input  logic [qmm_pkg::CFG_DATA_W-1:0]  wr_data,
	qmm_item_if.sink                        item,
	qmm_res_if.source                       result
);
	import qmm_pkg::*;

	// configuration registers
	logic [LIM_W-1:0] esc_low_limit_q;
	logic [ARM_W-1:0] arm_duration_q;

	// input stage
	logic  item_vld_s1;
	item_t item_s1;

	// sequencer side
	logic       take;
	logic       res_vld_s2;
	res_t       res_s2;
	width_vec_t mix_width;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_low_limit_q <= ESC_LOW_RESET;
			arm_duration_q  <= ARM_DUR_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_ESC_LOW_LIMIT: esc_low_limit_q <= wr_data[LIM_W-1:0];
				REG_ARM_DURATION: arm_duration_q <= wr_data[ARM_W-1:0];
			endcase
		end
	end

	// input register: free, or emptied by the sequencer in this cycle
	assign item.ready = !item_vld_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_vld_s1 <= 1'b0;
		end else if (item.ready) begin
			item_vld_s1 <= item.valid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1 <= '{kind: item.kind, throttle: item.throttle, pitch: item.pitch,
				roll: item.roll, yaw: item.yaw};
		end
	end

	// motor widths for mix and unarmed silent commands
	qmm_mixer u_mixer (
		.cmd           (item_s1),
		.esc_low_limit (esc_low_limit_q),
		.mix_width     (mix_width)
	);

	// mode, counters, pins and the result register
	qmm_seq u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_vld_s1   (item_vld_s1),
		.item_s1       (item_s1),
		.mix_width     (mix_width),
		.esc_low_limit (esc_low_limit_q),
		.arm_duration  (arm_duration_q),
		.res_ready     (result.ready),
		.take          (take),
		.res_vld_s2    (res_vld_s2),
		.res_s2        (res_s2)
	);

	assign result.valid      = res_vld_s2;
	assign result.motor_pins = res_s2.motor_pins;
	assign result.busy_res   = res_s2.busy_res;
	assign result.armed      = res_s2.armed;
	assign result.rejected   = res_s2.rejected;

`ifndef SYNTHESIS
	// a rejected command leaves a sequence running
	a_reject_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_vld_s2 && res_s2.rejected |-> res_s2.busy_res)
		else $error("rejected result without busy");

	// a raised pin always belongs to a running sequence
	a_pins_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_vld_s2 && (res_s2.motor_pins != '0) |-> res_s2.busy_res)
		else $error("pin high while idle");

	// an item held back by the result stage stays in the input register
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_vld_s1 && !take |=> item_vld_s1 && $stable(item_s1))
		else $error("input stage lost a held item");
`endif

endmodule

// ----- hw/rtl/qmm_mixer.sv -----
// ----------------------------------------------------------------------------
// qmm_mixer: x-frame motor mixer
// per-motor widths from throttle, pitch, roll and yaw, negative clamped to zero
// ----------------------------------------------------------------------------
module qmm_mixer (
	input  qmm_pkg::item_t             cmd,
	input  logic [qmm_pkg::LIM_W-1:0]  esc_low_limit,
	output qmm_pkg::width_vec_t        mix_width
);
	import qmm_pkg::*;

	// wide enough for throttle plus three full-scale corrections
	localparam int SUM_W = WID_W + 1;

	logic [SUM_W-1:0] t, p, r, y;
	logic [SUM_W-1:0] sum [NUM_MOTORS];

	always_comb begin
		if (cmd.kind == KIND_SILENT) begin
			t = SUM_W'(esc_low_limit) + SUM_W'(SILENT_OFFSET);
			p = '0;
			r = '0;
			y = '0;
		end else begin
			t = SUM_W'(cmd.throttle);
			p = SUM_W'(cmd.pitch);
			r = SUM_W'(cmd.roll);
			y = SUM_W'(cmd.yaw);
		end
		// back left, front left, back right, front right
		sum[0] = t - p - r - y;
		sum[1] = t + p - r + y;
		sum[2] = t - p + r + y;
		sum[3] = t + p + r - y;
		for (int i = 0; i < NUM_MOTORS; i++) begin
			mix_width[i] = sum[i][SUM_W-1] ? '0 : sum[i][WID_W-1:0];
		end
	end

endmodule

// ----- hw/rtl/qmm_seq.sv -----
// ----------------------------------------------------------------------------
// qmm_seq: pulse sequencer and result register
// applies one item per cycle, while the result register is not stalled, to the mode, counters and pin state
// ----------------------------------------------------------------------------
module qmm_seq (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_vld_s1,
	input  qmm_pkg::item_t             item_s1,
	input  qmm_pkg::width_vec_t        mix_width,
	input  logic [qmm_pkg::LIM_W-1:0]  esc_low_limit,
	input  logic [qmm_pkg::ARM_W-1:0]  arm_duration,
	input  logic                       res_ready,
	output logic                       take,
	output logic                       res_vld_s2,
	output qmm_pkg::res_t              res_s2
);
	import qmm_pkg::*;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_MIX,
		MODE_GAP,
		MODE_STOP,
		MODE_ARM_HIGH,
		MODE_ARM_LOW
	} mode_t;

	mode_t              mode_q, mode_d;
	logic [PHASE_W-1:0] phase_q, phase_d, phase_inc;
	logic [ARM_W-1:0]   arm_el_q, arm_el_d, arm_el_inc;
	width_vec_t         width_q, width_d;
	pins_t              pins_q, pins_d;
	logic               armed_q, armed_d;
	logic               rejected;
	logic               is_cmd;
	width_t             low_pulse;
	pins_t              drop, raise, mix_raise, lp_raise;

	assign take = item_vld_s1 && (!res_vld_s2 || res_ready);

	always_comb begin
		mode_d   = mode_q;
		phase_d  = phase_q;
		arm_el_d = arm_el_q;
		width_d  = width_q;
		pins_d   = pins_q;
		armed_d  = armed_q;
		rejected = 1'b0;

		low_pulse  = (esc_low_limit >= LOW_PULSE_OFFSET) ?
			WID_W'(esc_low_limit - LOW_PULSE_OFFSET) : '0;
		lp_raise   = (low_pulse != '0) ? '1 : '0;
		phase_inc  = phase_q + PHASE_W'(1);
		arm_el_inc = (arm_el_q != ARM_MAX) ? arm_el_q + ARM_W'(1) : arm_el_q;
		for (int i = 0; i < NUM_MOTORS; i++) begin
			drop[i]      = phase_inc >= PHASE_W'(width_q[i]);
			raise[i]     = width_q[i] != '0;
			mix_raise[i] = mix_width[i] != '0;
		end

		is_cmd = (item_s1.kind == KIND_MIX) || (item_s1.kind == KIND_ARM) ||
			(item_s1.kind == KIND_STOP) || (item_s1.kind == KIND_SILENT);

		if (item_s1.kind == KIND_TICK) begin
			unique case (mode_q)
				MODE_IDLE: mode_d = MODE_IDLE;
				MODE_GAP: mode_d = MODE_IDLE;
				MODE_MIX, MODE_STOP: begin
					phase_d = phase_inc;
					pins_d  = pins_q & ~drop;
					if (pins_d == '0) begin
						mode_d = (mode_q == MODE_MIX) ? MODE_GAP : MODE_IDLE;
					end
				end
				MODE_ARM_HIGH: begin
					arm_el_d = arm_el_inc;
					pins_d   = pins_q & ~drop;
					if (pins_d == '0) begin
						mode_d  = MODE_ARM_LOW;
						phase_d = '0;
					end else begin
						phase_d = phase_inc;
					end
				end
				MODE_ARM_LOW: begin
					arm_el_d = arm_el_inc;
					phase_d  = phase_inc;
					if (phase_inc >= ARM_LOW_TICKS) begin
						if (arm_el_inc <= arm_duration) begin
							// next arming cycle on the latched widths
							pins_d  = raise;
							phase_d = '0;
							mode_d  = (raise != '0) ? MODE_ARM_HIGH : MODE_ARM_LOW;
						end else begin
							armed_d = 1'b1;
							mode_d  = MODE_IDLE;
						end
					end
				end
				default: mode_d = MODE_IDLE;
			endcase
		end else if (is_cmd) begin
			if (mode_q != MODE_IDLE) begin
				rejected = 1'b1;
			end else begin
				unique case (item_s1.kind)
					KIND_ARM: begin
						arm_el_d = '0;
						width_d  = {NUM_MOTORS{low_pulse}};
						pins_d   = lp_raise;
						phase_d  = '0;
						mode_d   = (lp_raise != '0) ? MODE_ARM_HIGH : MODE_ARM_LOW;
					end
					KIND_STOP: begin
						width_d = {NUM_MOTORS{low_pulse}};
						pins_d  = lp_raise;
						phase_d = '0;
						mode_d  = (lp_raise != '0) ? MODE_STOP : MODE_IDLE;
					end
					KIND_SILENT: begin
						// armed: stop pulse, else mix at the silent throttle
						if (armed_q) begin
							width_d = {NUM_MOTORS{low_pulse}};
							pins_d  = lp_raise;
							phase_d = '0;
							mode_d  = (lp_raise != '0) ? MODE_STOP : MODE_IDLE;
						end else begin
							width_d = mix_width;
							pins_d  = mix_raise;
							phase_d = '0;
							mode_d  = (mix_raise != '0) ? MODE_MIX : MODE_GAP;
						end
					end
					default: begin
						width_d = mix_width;
						pins_d  = mix_raise;
						phase_d = '0;
						mode_d  = (mix_raise != '0) ? MODE_MIX : MODE_GAP;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_IDLE;
			phase_q    <= '0;
			arm_el_q   <= '0;
			width_q    <= '0;
			pins_q     <= '0;
			armed_q    <= 1'b0;
			res_vld_s2 <= 1'b0;
			res_s2     <= '0;
		end else if (take) begin
			mode_q     <= mode_d;
			phase_q    <= phase_d;
			arm_el_q   <= arm_el_d;
			width_q    <= width_d;
			pins_q     <= pins_d;
			armed_q    <= armed_d;
			res_vld_s2 <= 1'b1;
			res_s2     <= '{motor_pins: pins_d, busy_res: (mode_d != MODE_IDLE),
				armed: armed_d, rejected: rejected};
		end else if (res_ready) begin
			res_vld_s2 <= 1'b0;
		end
	end

endmodule
